[sv/ipps_pkg.sv]
// Shared types and constants for the incremental PID pedal split block.
package ipps_pkg;

  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int VEL_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DP_W    = 18;
  localparam int DD_W    = 19;
  localparam int OPA_W   = 17;
  localparam int OPB_W   = 25;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int INC_W   = 30;
  localparam int DRIVE_W = 24;
  localparam int SUM_W   = 31;
  localparam int PEDAL_W = 16;
  localparam int FRAC_W  = 8;

  localparam logic [IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [IDX_W-1:0] REG_RATIO_ACCEL = 3'd3;
  localparam logic [IDX_W-1:0] REG_RATIO_BRAKE = 3'd4;

  localparam logic signed [SUM_W-1:0] DRIVE_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] DRIVE_MIN = -SUM_W'(8388608);
  localparam logic [PEDAL_W-1:0] PEDAL_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_SUM,
    S_DRIVE,
    S_PEDAL,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MSEL_PROP,
    MSEL_INTEG,
    MSEL_DERIV,
    MSEL_PEDAL
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     inc_add;
    logic     drive_upd;
    logic     out_load;
  } ctrl_cmd_t;

endpackage

[sv/incremental_pid_pedal_split.sv]
// Top level: incremental PID speed controller with accelerator/brake split.
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per control step:
//   target and measured velocity plus the accumulate flag.
//   Output channel (out_valid/out_ready) returns one beat per input beat:
//   accelerator, brake and the drive accumulator after that step.
//   Config port (cfg_we/cfg_index/cfg_data) writes the three gains and two
//   pedal ratios in one cycle each; write only while the block is idle.
// Sequence:
//   One item at a time runs through these steps before the next is taken:
//   the accept, three gain passes through the shared multiplier, the add
//   of the last product, the drive update, the pedal ratio pass and the
//   output register load.
//   The output register is separate, so a new item is taken while a result
//   still waits. If the receiver stalls, the next result holds in the last
//   step until the output register frees, and input stays blocked.
// Reset: gains, ratios, error history and drive clear to zero; no result
//   is pending.
module incremental_pid_pedal_split (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ipps_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ipps_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ipps_pkg::VEL_W-1:0]   target_velocity,
  input  logic signed [ipps_pkg::VEL_W-1:0]   measured_velocity,
  input  logic                                accumulate_enable,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ipps_pkg::PEDAL_W-1:0]        accel_pedal,
  output logic [ipps_pkg::PEDAL_W-1:0]        brake_level,
  output logic signed [ipps_pkg::DRIVE_W-1:0] drive_value
);
  import ipps_pkg::*;

  ctrl_cmd_t cmd;

  ipps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ipps_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .target_velocity   (target_velocity),
    .measured_velocity (measured_velocity),
    .accumulate_enable (accumulate_enable),
    .cmd               (cmd),
    .accel_pedal       (accel_pedal),
    .brake_level       (brake_level),
    .drive_value       (drive_value)
  );

endmodule

[sv/ipps_dp.sv]
// Datapath: config registers, error history, shared multiplier, drive and pedals.
module ipps_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ipps_pkg::IDX_W-1:0]         cfg_index,
  input  logic [ipps_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [ipps_pkg::VEL_W-1:0]  target_velocity,
  input  logic signed [ipps_pkg::VEL_W-1:0]  measured_velocity,
  input  logic                               accumulate_enable,
  input  ipps_pkg::ctrl_cmd_t                cmd,
  output logic [ipps_pkg::PEDAL_W-1:0]       accel_pedal,
  output logic [ipps_pkg::PEDAL_W-1:0]       brake_level,
  output logic signed [ipps_pkg::DRIVE_W-1:0] drive_value
);
  import ipps_pkg::*;

  logic [CFG_W-1:0] gain_prop, gain_integ, gain_deriv, ratio_accel, ratio_brake;
  logic signed [ERR_W-1:0]   err, error_last, error_before_last;
  logic                      acc_en;
  logic signed [DRIVE_W-1:0] drive_accum;
  logic signed [INC_W-1:0]   inc;
  logic signed [PROD_W-1:0]  prod;

  logic signed [DP_W-1:0]    dp_diff;
  logic signed [DD_W-1:0]    dd_diff;
  logic signed [OPA_W-1:0]   opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [OPB_W-1:0]   drive_ext;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [SUM_W-1:0]   drive_sum;
  logic signed [DRIVE_W-1:0] drive_sat;
  logic [PEDAL_W-1:0]        pedal_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop   <= '0;
      gain_integ  <= '0;
      gain_deriv  <= '0;
      ratio_accel <= '0;
      ratio_brake <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:   gain_prop   <= cfg_data;
        REG_GAIN_INTEG:  gain_integ  <= cfg_data;
        REG_GAIN_DERIV:  gain_deriv  <= cfg_data;
        REG_RATIO_ACCEL: ratio_accel <= cfg_data;
        REG_RATIO_BRAKE: ratio_brake <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dp_diff = DP_W'(err) - DP_W'(error_last);
  assign dd_diff = DD_W'(err) - (DD_W'(error_last) <<< 1) + DD_W'(error_before_last);
  assign drive_ext = OPB_W'(drive_accum);

  always_comb begin
    case (cmd.mul_sel)
      MSEL_PROP: begin
        opa = $signed({1'b0, gain_prop});
        opb = OPB_W'(dp_diff);
      end
      MSEL_INTEG: begin
        opa = $signed({1'b0, gain_integ});
        opb = OPB_W'(err);
      end
      MSEL_DERIV: begin
        opa = $signed({1'b0, gain_deriv});
        opb = OPB_W'(dd_diff);
      end
      MSEL_PEDAL: begin
        opa = drive_accum[DRIVE_W-1] ? $signed({1'b0, ratio_brake})
                                     : $signed({1'b0, ratio_accel});
        opb = drive_accum[DRIVE_W-1] ? -drive_ext : drive_ext;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_sh   = prod >>> FRAC_W;
  assign drive_sum = SUM_W'(drive_accum) + SUM_W'(inc);

  always_comb begin
    if (drive_sum > DRIVE_MAX) begin
      drive_sat = DRIVE_W'(DRIVE_MAX);
    end else if (drive_sum < DRIVE_MIN) begin
      drive_sat = DRIVE_W'(DRIVE_MIN);
    end else begin
      drive_sat = DRIVE_W'(drive_sum);
    end
  end

  // product is non-negative here
  assign pedal_sat = (prod[PROD_W-1:PEDAL_W+FRAC_W] != '0) ? PEDAL_MAX
                                                           : prod[PEDAL_W+FRAC_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      error_last        <= '0;
      error_before_last <= '0;
      drive_accum       <= '0;
    end else if (cmd.drive_upd) begin
      error_last        <= err;
      error_before_last <= error_last;
      if (acc_en) begin
        drive_accum <= drive_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err    <= ERR_W'(target_velocity) - ERR_W'(measured_velocity);
      acc_en <= accumulate_enable;
      inc    <= '0;
    end else if (cmd.inc_add) begin
      inc <= inc + INC_W'(prod_sh);
    end
    if (cmd.mul_en) begin
      prod <= opa * opb;
    end
    if (cmd.out_load) begin
      drive_value <= drive_accum;
      if (drive_accum[DRIVE_W-1]) begin
        accel_pedal <= '0;
        brake_level <= pedal_sat;
      end else begin
        accel_pedal <= pedal_sat;
        brake_level <= '0;
      end
    end
  end

endmodule

[sv/ipps_ctrl.sv]
// Controller: sequences one item through the shared multiplier and owns the handshakes.
module ipps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ipps_pkg::ctrl_cmd_t cmd
);
  import ipps_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.mul_sel   = MSEL_PROP;
    cmd.inc_add   = 1'b0;
    cmd.drive_upd = 1'b0;
    cmd.out_load  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_PROP;
        state_next  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_INTEG;
        cmd.inc_add = 1'b1;
        state_next  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DERIV;
        cmd.inc_add = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.inc_add = 1'b1;
        state_next  = S_DRIVE;
      end
      S_DRIVE: begin
        cmd.drive_upd = 1'b1;
        state_next    = S_PEDAL;
      end
      S_PEDAL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_PEDAL;
        state_next  = S_OUT;
      end
      S_OUT: begin
        cmd.mul_sel = MSEL_PEDAL;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
